[rtl/core/kwm_pkg.sv]
// Package of shared types and constants for the sorted-run merge block.
`default_nettype none

package kwm_pkg;

    // Fixed field widths
    localparam int RUN_BITS = 4;
    localparam int CFG_BITS = 5;

    // Reset value of the runs-in-use register
    localparam logic [CFG_BITS-1:0] RUNS_RESET = 5'd16;

    // Sequencer states
    typedef enum logic
    {
        KWM_IDLE,
        KWM_EMIT
    } kwm_state_t;

    // Command broadcast to every cell of the sorted chain
    typedef struct packed
    {
        logic insert;
        logic pop;
    } kwm_op_t;

endpackage

`default_nettype wire

[rtl/core/kwm_if.sv]
// Channel interfaces: input items, results and the configuration write.
`default_nettype none

interface kwm_item_if
    import kwm_pkg::*;
#(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [RUN_BITS-1:0]         run_index;
    logic signed [WORD_BITS-1:0] word;
    logic                        run_empty;

    modport source (output valid, output run_index, output word, output run_empty,
                    input ready);
    modport sink   (input valid, input run_index, input word, input run_empty,
                    output ready);
endinterface

interface kwm_result_if
    import kwm_pkg::*;
#(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] out_word;
    logic [RUN_BITS-1:0]         refill_run;
    logic                        merge_done;

    modport source (output valid, output out_word, output refill_run, output merge_done,
                    input ready);
    modport sink   (input valid, input out_word, input refill_run, input merge_done,
                    output ready);
endinterface

interface kwm_cfg_if
    import kwm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] runs_in_use;

    modport source (output valid, output runs_in_use, input ready);
    modport sink   (input valid, input runs_in_use, output ready);
endinterface

`default_nettype wire

[rtl/core/kwm_cell.sv]
// One cell of the sorted chain: holds one (word, run) entry in ascending order.
`default_nettype none

module kwm_cell
    import kwm_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kwm_op_t                     op,
    input  wire logic signed [WORD_BITS-1:0] new_word,
    input  wire logic [RUN_BITS-1:0]         new_run,
    input  wire logic                        left_valid,
    input  wire logic signed [WORD_BITS-1:0] left_word,
    input  wire logic [RUN_BITS-1:0]         left_run,
    input  wire logic                        left_before,
    input  wire logic                        right_valid,
    input  wire logic signed [WORD_BITS-1:0] right_word,
    input  wire logic [RUN_BITS-1:0]         right_run,
    output logic                             valid,
    output logic signed [WORD_BITS-1:0]      word,
    output logic [RUN_BITS-1:0]              run,
    output logic                             new_first
);

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [WORD_BITS-1:0] word_reg;
    logic signed [WORD_BITS-1:0] word_next;
    logic [RUN_BITS-1:0]         run_reg;
    logic [RUN_BITS-1:0]         run_next;

    // New entry leaves before the held one: lower word, then lower run on a tie
    assign new_first = !valid_reg || (new_word < word_reg) ||
                       ((new_word == word_reg) && (new_run < run_reg));

    // Insert: take the new entry at the boundary, shift right past it; pop: shift left
    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        run_next   = run_reg;
        if (op.insert && new_first)
        begin
            if (left_before)
            begin
                valid_next = left_valid;
                word_next  = left_word;
                run_next   = left_run;
            end
            else
            begin
                valid_next = 1'b1;
                word_next  = new_word;
                run_next   = new_run;
            end
        end
        else if (op.pop)
        begin
            valid_next = right_valid;
            word_next  = right_word;
            run_next   = right_run;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        run_reg  <= run_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;
    assign run   = run_reg;

endmodule

`default_nettype wire

[rtl/core/kwm_chain.sv]
// Row of sorted cells forming the min-priority store; the head is the smallest entry.
`default_nettype none

module kwm_chain
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS  = 16,
    parameter int WORD_BITS = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kwm_op_t                     op,
    input  wire logic signed [WORD_BITS-1:0] new_word,
    input  wire logic [RUN_BITS-1:0]         new_run,
    output logic                             head_valid,
    output logic signed [WORD_BITS-1:0]      head_word,
    output logic [RUN_BITS-1:0]              head_run,
    output logic                             full
);

    logic                        cell_valid  [MAX_RUNS];
    logic signed [WORD_BITS-1:0] cell_word   [MAX_RUNS];
    logic [RUN_BITS-1:0]         cell_run    [MAX_RUNS];
    logic                        cell_before [MAX_RUNS];

    // Build the row and wire each cell to its neighbours
    for (genvar i = 0; i < MAX_RUNS; i++)
    begin : g_cell
        logic                        lv;
        logic signed [WORD_BITS-1:0] lw;
        logic [RUN_BITS-1:0]         lr;
        logic                        lb;
        logic                        rv;
        logic signed [WORD_BITS-1:0] rw;
        logic [RUN_BITS-1:0]         rr;

        if (i == 0)
        begin : g_first
            assign lv = 1'b0;
            assign lw = '0;
            assign lr = '0;
            assign lb = 1'b0;
        end
        else
        begin : g_mid_left
            assign lv = cell_valid[i-1];
            assign lw = cell_word[i-1];
            assign lr = cell_run[i-1];
            assign lb = cell_before[i-1];
        end

        if (i == MAX_RUNS - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rw = '0;
            assign rr = '0;
        end
        else
        begin : g_mid_right
            assign rv = cell_valid[i+1];
            assign rw = cell_word[i+1];
            assign rr = cell_run[i+1];
        end

        kwm_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .new_word    (new_word),
            .new_run     (new_run),
            .left_valid  (lv),
            .left_word   (lw),
            .left_run    (lr),
            .left_before (lb),
            .right_valid (rv),
            .right_word  (rw),
            .right_run   (rr),
            .valid       (cell_valid[i]),
            .word        (cell_word[i]),
            .run         (cell_run[i]),
            .new_first   (cell_before[i])
        );
    end

    assign head_valid = cell_valid[0];
    assign head_word  = cell_word[0];
    assign head_run   = cell_run[0];
    assign full       = cell_valid[MAX_RUNS-1];

endmodule

`default_nettype wire

[rtl/core/k_way_sorted_run_merge.sv]
// Top level of the k-way sorted-run merge: sequencer, result register and config.
//
// Usage: write runs_in_use on cfg (one beat, only while the block is idle).
// A pass begins with runs_in_use priming beats (clamped) on items, each the head
// word of a run or an empty mark. The beat that completes priming yields the first
// result; from then on every items beat (the run named by refill_run, or its
// empty mark) yields exactly one result. Results carry the smallest stored
// word and the run to refill; equal words leave lower run first. Once the
// store is empty a merge_done beat closes the pass and priming starts again.
// While merging, a new item is taken only after EMIT has popped the head for
// the last one; priming beats that give no result are taken every cycle. The
// accept cycle inserts the word into the chain of sorted cells (one compare
// per cell, all in parallel); EMIT then pops the head into the result
// register once it is free. A stalled receiver holds the result register;
// the next item is still taken and waits in the sequencer until the register
// frees. Reset empties the store, returns to priming, sets runs_in_use to 16.
`default_nettype none

module k_way_sorted_run_merge
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS  = 16,
    parameter int WORD_BITS = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    kwm_item_if.sink    items,
    kwm_result_if.source results,
    kwm_cfg_if.sink     cfg
);

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int EFF_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
    localparam logic [EFF_W-1:0] MAX_EFF = EFF_W'(MAX_RUNS);
    localparam logic [EFF_W-1:0] ONE_EFF = EFF_W'(1);

    kwm_state_t                  state_reg;
    kwm_state_t                  state_next;
    logic                        merging_reg;
    logic                        merging_next;
    logic [EFF_W-1:0]            primed_reg;
    logic [EFF_W-1:0]            primed_next;
    logic [CFG_BITS-1:0]         runs_in_use_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [WORD_BITS-1:0] out_word_reg;
    logic [RUN_BITS-1:0]         out_run_reg;
    logic                        out_done_reg;

    kwm_op_t                     op;
    logic                        load_out;
    logic                        item_fire;
    logic                        slot_free;
    logic [EFF_W-1:0]            runs_ext;
    logic [EFF_W-1:0]            eff;
    logic [EFF_W-1:0]            primed_inc;
    logic                        head_valid;
    logic signed [WORD_BITS-1:0] head_word;
    logic [RUN_BITS-1:0]         head_run;
    logic                        full;

    // Sorted store
    kwm_chain #(
        .MAX_RUNS  (MAX_RUNS),
        .WORD_BITS (WORD_BITS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .new_word   (items.word),
        .new_run    (items.run_index),
        .head_valid (head_valid),
        .head_word  (head_word),
        .head_run   (head_run),
        .full       (full)
    );

    // Handshakes
    assign items.ready = (state_reg == KWM_IDLE);
    assign item_fire   = items.valid && items.ready;
    assign slot_free   = !out_valid_reg || results.ready;
    assign cfg.ready   = 1'b1;

    // Clamp the run count to 1..MAX_RUNS
    assign runs_ext   = EFF_W'(runs_in_use_reg);
    assign eff        = (runs_ext == '0) ? ONE_EFF :
                        ((runs_ext > MAX_EFF) ? MAX_EFF : runs_ext);
    assign primed_inc = primed_reg + ONE_EFF;

    // Sequencer: insert on accept, then pop the head into the result register
    always_comb
    begin
        state_next   = state_reg;
        merging_next = merging_reg;
        primed_next  = primed_reg;
        op           = '0;
        load_out     = 1'b0;
        unique case (state_reg)
            KWM_IDLE:
            begin
                if (item_fire)
                begin
                    // drop the word when the store is already full
                    op.insert = !items.run_empty && !full;
                    if (merging_reg)
                        state_next = KWM_EMIT;
                    else
                    begin
                        primed_next = primed_inc;
                        if (primed_inc >= eff)
                        begin
                            merging_next = 1'b1;
                            state_next   = KWM_EMIT;
                        end
                    end
                end
            end
            KWM_EMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = KWM_IDLE;
                    if (head_valid)
                        op.pop = 1'b1;
                    else
                    begin
                        // store drained: close the pass
                        merging_next = 1'b0;
                        primed_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = KWM_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= KWM_IDLE;
            merging_reg     <= 1'b0;
            primed_reg      <= '0;
            out_valid_reg   <= 1'b0;
            runs_in_use_reg <= RUNS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            merging_reg   <= merging_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                runs_in_use_reg <= cfg.runs_in_use;
        end
    end

    // Result payload: zeros on the end beat
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_word_reg <= head_valid ? head_word : '0;
            out_run_reg  <= head_valid ? head_run : '0;
            out_done_reg <= !head_valid;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_word   = out_word_reg;
    assign results.refill_run = out_run_reg;
    assign results.merge_done = out_done_reg;

`ifndef SYNTHESIS
    // A full store always has a head
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> head_valid)
        else $error("store full with empty head cell");

    // Never insert and pop in the same cycle
    a_op_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.insert && op.pop))
        else $error("insert and pop together");

    // An end beat returns the block to priming
    a_done_resets_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !head_valid) |=> (!merging_reg && primed_reg == '0))
        else $error("pass not closed after end beat");

    // End beats carry zero word and run
    a_done_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.merge_done) |->
            (results.out_word == '0 && results.refill_run == '0))
        else $error("end beat with non-zero payload");

    // Early priming beats produce no result
    a_priming_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !merging_reg && primed_inc < eff) |=> (state_reg == KWM_IDLE))
        else $error("result started during priming");
`endif

endmodule

`default_nettype wire

[dv/kwm_merge_sb_pkg.sv]
// Scoreboard for the sorted-run merge: priority-store predictor and result checker.
package kwm_merge_sb_pkg;

    import kwm_pkg::*;

    localparam int MERGE_DEPTH     = 16;
    localparam int MERGE_WORD_BITS = 32;

    // One result beat as the block presents it
    typedef struct packed
    {
        logic signed [MERGE_WORD_BITS-1:0] out_word;
        logic [RUN_BITS-1:0]               refill_run;
        logic                              merge_done;
    } merge_beat_t;

    class merge_scoreboard;

        // Predicted store contents, unordered; the minimum is found by a scan
        logic signed [MERGE_WORD_BITS-1:0] held_word [MERGE_DEPTH];
        logic [RUN_BITS-1:0]               held_run  [MERGE_DEPTH];
        int                                held_count;
        int                                primed_count;
        bit                                merging;
        logic [CFG_BITS-1:0]               runs_cfg;
        logic [RUN_BITS-1:0]               last_refill;
        merge_beat_t                       due_q [$];
        int                                errors;

        function new();
            held_count   = 0;
            primed_count = 0;
            merging      = 1'b0;
            runs_cfg     = RUNS_RESET;
            last_refill  = '0;
            errors       = 0;
        endfunction

        function void set_runs(logic [CFG_BITS-1:0] value);
            runs_cfg = value;
        endfunction

        // Clamp the register to the range the block honours
        function int effective_runs();
            if (runs_cfg == 0)
                return 1;
            if (runs_cfg > MERGE_DEPTH)
                return MERGE_DEPTH;
            return int'(runs_cfg);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("MISMATCH %s", msg);
        endtask

        // Store the word, advance priming, and predict the result it causes
        task note_item(logic [RUN_BITS-1:0] run, logic signed [MERGE_WORD_BITS-1:0] w,
                       logic empty);
            merge_beat_t beat;
            int          best;
            if (!empty && held_count < MERGE_DEPTH)
            begin
                held_word[held_count] = w;
                held_run[held_count]  = run;
                held_count++;
            end
            if (!merging)
            begin
                primed_count++;
                if (primed_count < effective_runs())
                    return;
                merging = 1'b1;
            end
            if (held_count == 0)
            begin
                beat.out_word   = '0;
                beat.refill_run = '0;
                beat.merge_done = 1'b1;
                merging         = 1'b0;
                primed_count    = 0;
            end
            else
            begin
                // Pick the smallest word; equal words leave lower run first
                best = 0;
                for (int i = 1; i < held_count; i++)
                begin
                    if (held_word[i] < held_word[best] ||
                        (held_word[i] == held_word[best] && held_run[i] < held_run[best]))
                        best = i;
                end
                beat.out_word   = held_word[best];
                beat.refill_run = held_run[best];
                beat.merge_done = 1'b0;
                last_refill     = held_run[best];
                held_count--;
                held_word[best] = held_word[held_count];
                held_run[best]  = held_run[held_count];
            end
            due_q.push_back(beat);
        endtask

        // Compare an accepted result with the oldest prediction
        task check_result(merge_beat_t got);
            merge_beat_t want;
            if (due_q.size() == 0)
            begin
                report($sformatf("unexpected result word=%0d run=%0d done=%0b",
                                 got.out_word, got.refill_run, got.merge_done));
                return;
            end
            want = due_q.pop_front();
            if (got.merge_done !== want.merge_done)
                report($sformatf("merge_done got %0b want %0b", got.merge_done,
                                 want.merge_done));
            if (got.out_word !== want.out_word)
                report($sformatf("out_word got %0d want %0d", got.out_word, want.out_word));
            if (got.refill_run !== want.refill_run)
                report($sformatf("refill_run got %0d want %0d", got.refill_run,
                                 want.refill_run));
        endtask

    endclass

endpackage

[dv/tb_top.sv]
// Top-level testbench for the sorted-run merge: stimulus, receiver, monitor and watchdog.
module tb_top;

    import kwm_pkg::*;
    import kwm_merge_sb_pkg::*;

    localparam int MAX_RUNS       = 16;
    localparam int WORD_BITS      = 32;
    localparam int ITEM_TARGET    = 1750;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [WORD_BITS-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;

    kwm_item_if   #(.WORD_BITS(WORD_BITS)) item_ch ();
    kwm_result_if #(.WORD_BITS(WORD_BITS)) res_ch ();
    kwm_cfg_if                             cfg_ch ();

    k_way_sorted_run_merge #(
        .MAX_RUNS  (MAX_RUNS),
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    merge_scoreboard sb = new();

    // Words still to be supplied for each run in the current pass
    logic signed [WORD_BITS-1:0] run_data [MAX_RUNS][$];
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hold the sender until every predicted result has been taken
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Send one item beat, in bursts with random gaps and the odd full drain
    task automatic send_item(logic [RUN_BITS-1:0] run, logic signed [WORD_BITS-1:0] w,
                             logic empty);
        int  gap;
        bit  drain;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            drain = ($urandom_range(0, 15) == 0);
            if (drain && gap == 0)
                gap = 1;
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                if (drain)
                    wait_drained();
            end
        end
        item_ch.valid     <= 1'b1;
        item_ch.run_index <= run;
        item_ch.word      <= w;
        item_ch.run_empty <= empty;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(run, w, empty);
        burst_left--;
        items_sent++;
    endtask

    // Write the run count once the block is idle between passes
    task automatic write_runs(logic [CFG_BITS-1:0] value);
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.runs_in_use <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.set_runs(value);
    endtask

    // Feed the next word of a run, its empty mark, or now and then a stray beat
    task automatic feed_run(int run, int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            send_item(RUN_BITS'($urandom_range(0, MAX_RUNS - 1)), $urandom,
                      1'($urandom_range(0, 1)));
        else if (run_data[run].size() == 0)
            send_item(RUN_BITS'(run), $urandom, 1'b1);
        else
            send_item(RUN_BITS'(run), run_data[run].pop_front(), 1'b0);
    endtask

    // Prime effective_runs runs in shuffled order, then follow the predicted refill run
    task automatic run_pass(int noise_pct);
        int order [MAX_RUNS];
        int n;
        int p;
        int j;
        int t;
        n = sb.effective_runs();
        for (p = 0; p < MAX_RUNS; p++)
            order[p] = p;
        for (p = MAX_RUNS - 1; p > 0; p--)
        begin
            j        = $urandom_range(0, p);
            t        = order[p];
            order[p] = order[j];
            order[j] = t;
        end
        for (p = 0; p < n; p++)
            feed_run(order[p], noise_pct);
        while (sb.merging)
            feed_run(int'(sb.last_refill), noise_pct);
    endtask

    // Build ascending runs: tight ties, wide spread, or pinned at the extremes
    task automatic fill_runs(int max_len);
        longint acc;
        longint step;
        int     len;
        int     mode;
        mode = $urandom_range(0, 2);
        for (int r = 0; r < MAX_RUNS; r++)
        begin
            run_data[r].delete();
            len = $urandom_range(0, max_len);
            case (mode)
                0:       acc = int'($urandom_range(0, 6)) - 3;
                1:       acc = longint'($signed($urandom));
                default: acc = -64'sd2147483648 + $urandom_range(0, 2);
            endcase
            for (int k = 0; k < len; k++)
            begin
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                run_data[r].push_back(acc[WORD_BITS-1:0]);
                case (mode)
                    0:       step = $urandom_range(0, 1);
                    1:       step = $urandom_range(0, 1 << 26);
                    default: step = ($urandom_range(0, 3) == 0) ? (longint'(1) << 31)
                                                                : $urandom_range(0, 1);
                endcase
                acc = acc + step;
            end
        end
    endtask

    // Receiver: ready pattern changes every segment
    initial
    begin
        int seg;
        int mode;
        int k;
        int phase;
        res_ch.ready = 1'b0;
        phase        = 0;
        forever
        begin
            seg  = $urandom_range(20, 120);
            mode = $urandom_range(0, 3);
            k    = $urandom_range(2, 6);
            repeat (seg)
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= (phase % k) == 0;
                    default: res_ch.ready <= ($urandom_range(0, 11) == 0);
                endcase
            end
        end
    end

    // Monitor: check every result beat
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{out_word: res_ch.out_word, refill_run: res_ch.refill_run,
                              merge_done: res_ch.merge_done});
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("WATCHDOG no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [CFG_BITS-1:0] cfg_seq [8];
        int pass_no;
        cfg_seq = '{5'd2, 5'd16, 5'd1, 5'd5, 5'd0, 5'd17, 5'd8, 5'd31};
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.run_index  = '0;
        item_ch.word       = '0;
        item_ch.run_empty  = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.runs_in_use = RUNS_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset run count: extremes, ties across runs, most runs empty
        for (int r = 0; r < MAX_RUNS; r++)
            run_data[r].delete();
        run_data[0] = '{WORD_MIN, WORD_MIN};
        run_data[1] = '{WORD_MAX};
        run_data[2] = '{-32'sd1};
        run_data[3] = '{32'sd0, 32'sd0};
        run_data[4] = '{-32'sd1};
        run_pass(0);

        // Zero acts as one: a lone empty mark ends the pass at once
        write_runs(5'd0);
        send_item(4'd0, WORD_MAX, 1'b1);

        // One run; the refill comes in under another run number
        write_runs(5'd1);
        send_item(4'd0, 32'sd7, 1'b0);
        send_item(4'd9, 32'sd123, 1'b0);
        send_item(4'd9, -32'sd5, 1'b1);

        // Above the store size acts as the store size
        write_runs(5'd31);

        // Random passes, mostly well formed, some pure noise
        pass_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (pass_no > 0 && pass_no % 3 == 0)
                write_runs((pass_no / 3 <= 8) ? cfg_seq[pass_no / 3 - 1]
                                              : CFG_BITS'($urandom_range(0, 31)));
            fill_runs(($urandom_range(0, 7) == 0) ? 24 : 8);
            if ($urandom_range(0, 7) == 0)
                run_pass(100);
            else
                run_pass($urandom_range(0, 6));
            pass_no++;
        end

        // Drain and settle
        item_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/kwm_pkg.sv
rtl/core/kwm_if.sv
rtl/core/kwm_cell.sv
rtl/core/kwm_chain.sv
rtl/core/k_way_sorted_run_merge.sv
dv/kwm_merge_sb_pkg.sv
dv/tb_top.sv
